>>> hw/rtl/spsc_pkg.sv
// Shared widths, constants, register indexes and sequencer states of the speed controller.
package spsc_pkg;

  localparam int OUTPUT_LIMIT_DEF = 1000;

  localparam int SPD_W = 16;
  localparam int MS_W  = 16;
  localparam int POW_W = 11;
  localparam int CFG_W = 32;
  localparam int IDX_W = 3;

  localparam int EW    = 17;
  localparam int LW    = 18;
  localparam int ACC_W = 40;
  localparam int SW    = 56;
  localparam int NW    = 53;
  localparam int MPW   = 20;
  localparam int DVW   = 20;
  localparam int RW    = DVW + 1;
  localparam int PW    = 16;
  localparam int CW    = $clog2(NW + 1);

  localparam int SCALE_SHIFT = 8;
  localparam int MAG_W       = SW - SCALE_SHIFT;

  localparam logic signed [SPD_W-1:0] TARGET_CLAMP = 16'sd15000;
  localparam logic [MPW-1:0]          MICRO        = 20'd1000000;
  localparam longint                  DEADBAND_THRESHOLD = 64'sd2560000;

  localparam logic [15:0] PROP_GAIN_RST      = 16'd2560;
  localparam logic [15:0] INTEG_GAIN_RST     = 16'd6400;
  localparam logic [15:0] DERIV_GAIN_RST     = 16'd0;
  localparam logic [31:0] INTEGRAL_LIMIT_RST = 32'd1000000;
  localparam logic [9:0]  DEADBAND_RST       = 10'd0;

  localparam logic [IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] REG_DEADBAND       = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR_MS,
    ST_CLAMP,
    ST_PTERM,
    ST_ITERM,
    ST_DPROD,
    ST_DSCALE,
    ST_DDIV,
    ST_DADD,
    ST_DBCHK,
    ST_DBAND,
    ST_SIGN,
    ST_QDIV,
    ST_FIN
  } state_t;

endpackage

>>> hw/rtl/spsc_if.sv
// Valid/ready channel interfaces for the speed controller's sample and power beats.
interface spsc_in_if import spsc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SPD_W-1:0] target_speed;
  logic signed [SPD_W-1:0] measured_speed;
  logic [MS_W-1:0]         elapsed_ms;

  modport source (output valid, target_speed, measured_speed, elapsed_ms, input ready);
  modport sink   (input valid, target_speed, measured_speed, elapsed_ms, output ready);
endinterface

interface spsc_out_if import spsc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POW_W-1:0] drive_power;

  modport source (output valid, drive_power, input ready);
  modport sink   (input valid, drive_power, output ready);
endinterface

>>> hw/rtl/split_pid_speed_controller_unit.sv
// PID speed controller with clamped integral, deadband offset and saturated power output.
//
// A sample beat on in_ch (target, measured speed, elapsed ms) is taken only while the
// sequencer is idle; one item is worked on at a time. A sample with zero elapsed time
// gives no power beat (a zero target still clears the integral and last error). Every
// other sample gives one power beat on out_ch through an output register, so a new
// sample may be taken while the previous power still waits for its receiver.
// The work is done by one shared shift-add multiplier (one multiplier bit per cycle,
// stopping at the top set bit) and one shared restoring divider (one quotient bit per
// cycle). The steps are the error-times-ms multiply, the integral clamp, and the
// proportional, integral and derivative multiplies. A nonzero derivative product is
// then scaled by 10^6 and divided by ms in a 53-step divide. When the deadband offset
// applies, it is a further multiply. Last comes the power quotient divide, which is
// skipped when the power saturates or opposes the target. A zero-target sample goes
// straight to the final state.
// If the receiver stalls, the finished power waits in the final state until the
// output register is free. Synchronous reset returns the sequencer to idle, empties
// the output register, clears the integral and last error and loads the default
// register values. Configuration writes are taken at any edge with wr_en high.
module split_pid_speed_controller_unit import spsc_pkg::*; #(
  parameter int OUTPUT_LIMIT = OUTPUT_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  spsc_in_if.sink          in_ch,
  spsc_out_if.source       out_ch,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data
);

  localparam int QB = $clog2(OUTPUT_LIMIT + 1);
  localparam logic [MAG_W-1:0] SAT_LEVEL =
    MAG_W'((64'(OUTPUT_LIMIT) + 64'd1) * 64'(MICRO));
  localparam logic signed [SW-1:0] DB_HI  = SW'(DEADBAND_THRESHOLD);
  localparam logic signed [PW-1:0] LIM_PW = PW'(OUTPUT_LIMIT);

  state_t state, state_next;

  logic [15:0] prop_gain;
  logic [15:0] integ_gain;
  logic [15:0] deriv_gain;
  logic [31:0] integral_limit;
  logic [9:0]  deadband;

  logic signed [ACC_W-1:0] acc;
  logic signed [LW-1:0]    last_err;

  logic signed [SPD_W-1:0] tgt;
  logic signed [EW-1:0]    err;
  logic signed [LW-1:0]    diff;
  logic [MS_W-1:0]         ms;

  logic signed [SW-1:0] s_sum;
  logic signed [SW-1:0] prod;
  logic signed [SW-1:0] mcand;
  logic [MPW-1:0]       mplier;
  logic [NW-1:0]        dq;
  logic [RW-1:0]        rem;
  logic [DVW-1:0]       dvs;
  logic [CW-1:0]        cnt;
  logic                 neg;
  logic signed [PW-1:0] power;

  logic                    out_valid;
  logic signed [POW_W-1:0] out_data;

  logic                    in_accept;
  logic                    out_free;
  logic signed [SPD_W-1:0] tgt_in;
  logic signed [EW-1:0]    err_in;
  logic signed [LW-1:0]    diff_in;
  logic signed [SW-1:0]    err_w;
  logic signed [SW-1:0]    err_k;
  logic signed [SW-1:0]    db_w;
  logic signed [SW-1:0]    lim_pos;
  logic signed [SW-1:0]    acc_clamped;
  logic signed [SW-1:0]    prod_step;
  logic [SW-1:0]           abs_prod;
  logic [MAG_W-1:0]        mag;
  logic                    mul_state;
  logic                    mul_done;
  logic                    mul_run;
  logic                    div_run;
  logic [RW-1:0]           rem_sh;
  logic                    div_ge;
  logic [RW-1:0]           rem_step;
  logic                    opp;
  logic                    sat;
  logic signed [PW-1:0]    q_pw;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  always_comb begin
    if (in_ch.target_speed > TARGET_CLAMP) begin
      tgt_in = TARGET_CLAMP;
    end else if (in_ch.target_speed < -TARGET_CLAMP) begin
      tgt_in = -TARGET_CLAMP;
    end else begin
      tgt_in = in_ch.target_speed;
    end
  end

  assign err_in  = EW'(tgt_in) - EW'(in_ch.measured_speed);
  assign diff_in = LW'(err_in) - last_err;

  // Times 1000 as 1024 - 16 - 8.
  assign err_w = SW'(err);
  assign err_k = (err_w <<< 10) - (err_w <<< 4) - (err_w <<< 3);
  assign db_w  = SW'({deadband, {SCALE_SHIFT{1'b0}}});

  assign lim_pos = SW'({1'b0, integral_limit});
  always_comb begin
    if (prod > lim_pos) begin
      acc_clamped = lim_pos;
    end else if (prod < -lim_pos) begin
      acc_clamped = -lim_pos;
    end else begin
      acc_clamped = prod;
    end
  end

  assign mul_state = (state == ST_ERR_MS) || (state == ST_PTERM) || (state == ST_ITERM) ||
                     (state == ST_DPROD) || (state == ST_DSCALE) || (state == ST_DBAND);
  assign mul_done  = (mplier == '0);
  assign mul_run   = mul_state && !mul_done;
  assign prod_step = mplier[0] ? prod + mcand : prod;

  assign div_run  = ((state == ST_DDIV) || (state == ST_QDIV)) && (cnt != '0);
  assign rem_sh   = {rem[RW-2:0], dq[NW-1]};
  assign div_ge   = (rem_sh >= RW'(dvs));
  assign rem_step = div_ge ? rem_sh - RW'(dvs) : rem_sh;

  assign abs_prod = prod[SW-1] ? -prod : prod;
  assign mag      = abs_prod[SW-1:SCALE_SHIFT];
  assign opp      = ((tgt > 0) && (prod < 0)) || ((tgt < 0) && (prod > 0));
  assign sat      = (mag >= SAT_LEVEL);
  assign q_pw     = PW'(dq[QB-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= PROP_GAIN_RST;
      integ_gain     <= INTEG_GAIN_RST;
      deriv_gain     <= DERIV_GAIN_RST;
      integral_limit <= INTEGRAL_LIMIT_RST;
      deadband       <= DEADBAND_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PROP_GAIN:      prop_gain      <= wr_data[15:0];
        REG_INTEG_GAIN:     integ_gain     <= wr_data[15:0];
        REG_DERIV_GAIN:     deriv_gain     <= wr_data[15:0];
        REG_INTEGRAL_LIMIT: integral_limit <= wr_data[31:0];
        REG_DEADBAND:       deadband       <= wr_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && (in_ch.elapsed_ms != '0)) begin
          state_next = (tgt_in == '0) ? ST_FIN : ST_ERR_MS;
        end
      end
      ST_ERR_MS: if (mul_done) state_next = ST_CLAMP;
      ST_CLAMP:  state_next = ST_PTERM;
      ST_PTERM:  if (mul_done) state_next = ST_ITERM;
      ST_ITERM:  if (mul_done) state_next = ST_DPROD;
      ST_DPROD:  if (mul_done) state_next = (prod != '0) ? ST_DSCALE : ST_DBCHK;
      ST_DSCALE: if (mul_done) state_next = ST_DDIV;
      ST_DDIV:   if (cnt == '0) state_next = ST_DADD;
      ST_DADD:   state_next = ST_DBCHK;
      ST_DBCHK:  state_next = ST_DBAND;
      ST_DBAND:  if (mul_done) state_next = ST_SIGN;
      ST_SIGN:   state_next = (opp || sat) ? ST_FIN : ST_QDIV;
      ST_QDIV:   if (cnt == '0) state_next = ST_FIN;
      ST_FIN:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Datapath: the shared multiplier and divider step here, setups happen on phase ends.
  always_ff @(posedge clk) begin
    if (mul_run) begin
      prod   <= prod_step;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
    if (div_run) begin
      rem <= rem_step;
      dq  <= {dq[NW-2:0], div_ge};
      cnt <= cnt - CW'(1);
    end
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          tgt  <= tgt_in;
          err  <= err_in;
          diff <= diff_in;
          ms   <= in_ch.elapsed_ms;
          if (in_ch.elapsed_ms != '0) begin
            if (tgt_in == '0) begin
              power <= '0;
            end else begin
              prod   <= SW'(acc);
              mcand  <= SW'(err_in);
              mplier <= MPW'(in_ch.elapsed_ms);
            end
          end
        end
      end
      ST_CLAMP: begin
        prod   <= '0;
        mcand  <= err_k;
        mplier <= MPW'(prop_gain);
      end
      ST_PTERM: begin
        if (mul_done) begin
          mcand  <= SW'(acc);
          mplier <= MPW'(integ_gain);
        end
      end
      ST_ITERM: begin
        if (mul_done) begin
          s_sum  <= prod;
          prod   <= '0;
          mcand  <= SW'(diff);
          mplier <= MPW'(deriv_gain);
        end
      end
      ST_DPROD: begin
        if (mul_done && (prod != '0)) begin
          mcand  <= prod;
          prod   <= '0;
          mplier <= MICRO;
        end
      end
      ST_DSCALE: begin
        // The quotient is formed on the magnitude so that it truncates toward zero.
        if (mul_done) begin
          neg <= prod[SW-1];
          dq  <= abs_prod[NW-1:0];
          rem <= '0;
          dvs <= DVW'(ms);
          cnt <= CW'(NW);
        end
      end
      ST_DADD: begin
        s_sum <= neg ? s_sum - SW'(dq) : s_sum + SW'(dq);
      end
      ST_DBCHK: begin
        prod <= s_sum;
        if (s_sum > DB_HI) begin
          mcand  <= db_w;
          mplier <= MICRO;
        end else if (s_sum < -DB_HI) begin
          mcand  <= -db_w;
          mplier <= MICRO;
        end else begin
          mplier <= '0;
        end
      end
      ST_SIGN: begin
        neg <= prod[SW-1];
        if (opp) begin
          power <= '0;
        end else if (sat) begin
          power <= prod[SW-1] ? -LIM_PW : LIM_PW;
        end else begin
          // The quotient is known to fit in QB bits, so the top of the dividend
          // already sits below the divisor.
          rem <= RW'(mag >> QB);
          dq  <= {mag[QB-1:0], {(NW-QB){1'b0}}};
          dvs <= DVW'(MICRO);
          cnt <= CW'(QB);
        end
      end
      ST_QDIV: begin
        if (cnt == '0) begin
          power <= neg ? -q_pw : q_pw;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      last_err <= '0;
    end else begin
      if ((state == ST_IDLE) && in_accept) begin
        if (in_ch.elapsed_ms == '0) begin
          if (tgt_in == '0) begin
            acc      <= '0;
            last_err <= '0;
          end
        end else begin
          last_err <= LW'(err_in);
          if (tgt_in == '0) begin
            acc <= '0;
          end
        end
      end else if (state == ST_CLAMP) begin
        acc <= acc_clamped[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      out_data <= power[POW_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.drive_power = out_data;

endmodule

>>> tb/tb_split_pid_speed_controller_unit.sv
// Self-checking testbench of the split PID speed controller: directed and random samples.
module tb_split_pid_speed_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import spsc_pkg::*;

  localparam int     SETTLE_CYCLES = 200;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     RAND_PHASES   = 8;
  localparam int     PHASE_ITEMS   = 229;
  localparam longint TIMEOUT_NS    = 64'd20000000;
  localparam longint POWER_UNIT    = 64'sd256000000;
  localparam longint DERIV_SCALE   = 64'sd1000000;

  localparam logic [IDX_W-1:0] REG_UNMAPPED = REG_DEADBAND + 1'b1;

  class power_scoreboard;
    logic [15:0]             prop_gain;
    logic [15:0]             integ_gain;
    logic [15:0]             deriv_gain;
    logic [31:0]             integral_limit;
    logic [9:0]              deadband;
    logic signed [ACC_W-1:0] integ_sum;
    logic signed [LW-1:0]    prev_err;
    logic [POW_W-1:0]        expected_power[$];
    int                      errors;

    function new();
      prop_gain      = PROP_GAIN_RST;
      integ_gain     = INTEG_GAIN_RST;
      deriv_gain     = DERIV_GAIN_RST;
      integral_limit = INTEGRAL_LIMIT_RST;
      deadband       = DEADBAND_RST;
      integ_sum      = '0;
      prev_err       = '0;
      errors         = 0;
    endfunction

    function void set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      case (idx)
        REG_PROP_GAIN:      prop_gain = val[15:0];
        REG_INTEG_GAIN:     integ_gain = val[15:0];
        REG_DERIV_GAIN:     deriv_gain = val[15:0];
        REG_INTEGRAL_LIMIT: integral_limit = val[31:0];
        REG_DEADBAND:       deadband = val[9:0];
        default: ;
      endcase
    endfunction

    // Works out the power command that an accepted sample causes, if any.
    function void note_sample(input logic signed [SPD_W-1:0] tgt_in,
                              input logic signed [SPD_W-1:0] meas_in,
                              input logic [MS_W-1:0] ms_in);
      longint tgt, meas, dur, err, lim, acc, cmd, pwr;
      tgt  = longint'(tgt_in);
      meas = longint'(meas_in);
      dur  = longint'(ms_in);
      if (tgt > longint'(TARGET_CLAMP)) tgt = longint'(TARGET_CLAMP);
      if (tgt < -longint'(TARGET_CLAMP)) tgt = -longint'(TARGET_CLAMP);
      // A zero target clears the history even when the sample is skipped.
      if (tgt == 0) begin
        integ_sum = '0;
        prev_err  = '0;
      end
      if (dur == 0) return;
      err = tgt - meas;
      lim = longint'(integral_limit);
      if (tgt != 0) begin
        acc = longint'(integ_sum) + err * dur;
        if (acc > lim) acc = lim;
        else if (acc < -lim) acc = -lim;
        integ_sum = acc[ACC_W-1:0];
      end else begin
        integ_sum = '0;
      end
      cmd = longint'(prop_gain) * err * 64'sd1000
          + longint'(integ_gain) * longint'(integ_sum)
          + (longint'(deriv_gain) * (err - longint'(prev_err)) * DERIV_SCALE) / dur;
      if (cmd > DEADBAND_THRESHOLD) cmd = cmd + longint'(deadband) * POWER_UNIT;
      else if (cmd < -DEADBAND_THRESHOLD) cmd = cmd - longint'(deadband) * POWER_UNIT;
      if (tgt > 0) begin
        if (cmd < 0) cmd = 0;
      end else if (tgt < 0) begin
        if (cmd > 0) cmd = 0;
      end else begin
        cmd = 0;
      end
      pwr = cmd / POWER_UNIT;
      if (pwr > OUTPUT_LIMIT_DEF) pwr = OUTPUT_LIMIT_DEF;
      else if (pwr < -OUTPUT_LIMIT_DEF) pwr = -OUTPUT_LIMIT_DEF;
      prev_err = err[LW-1:0];
      expected_power.push_back(pwr[POW_W-1:0]);
    endfunction

    function void check_power(input logic [POW_W-1:0] actual);
      logic [POW_W-1:0] want;
      if (expected_power.size() == 0) begin
        $display("%0t: unexpected drive_power beat: expected none, actual %0d",
                 $time, $signed(actual));
        errors++;
      end else begin
        want = expected_power.pop_front();
        if (actual !== want) begin
          $display("%0t: drive_power mismatch: expected %0d, actual %0d",
                   $time, $signed(want), $signed(actual));
          errors++;
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;
  logic             burst;
  int               hold_requests;

  spsc_in_if  in_ch ();
  spsc_out_if out_ch ();

  power_scoreboard sb = new();

  split_pid_speed_controller_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // The receiver idles at random, and holds off for a long stretch on request.
  initial begin
    int hold_left;
    int hold_served;
    hold_left    = 0;
    hold_served  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ch.ready = 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left    = HOLD_CYCLES;
        out_ch.ready = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = burst || ($urandom_range(99) >= 20);
      end
    end
  end

  // Power beats are checked before the sample of the same edge is noted, as the
  // output register can only hold the result of an earlier sample.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) sb.check_power(out_ch.drive_power);
      if (in_ch.valid && in_ch.ready)
        sb.note_sample(in_ch.target_speed, in_ch.measured_speed, in_ch.elapsed_ms);
    end
  end

  // Leaves valid high after the beat, so the caller offers the next sample or
  // lowers valid at the same falling edge.
  task automatic send_sample(input int tgt, input int meas, input int dur);
    while (!burst && $urandom_range(99) < 20) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.target_speed   = SPD_W'(tgt);
    in_ch.measured_speed = SPD_W'(meas);
    in_ch.elapsed_ms     = MS_W'(dur);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic quiesce(input int extra);
    in_ch.valid = 1'b0;
    while (sb.expected_power.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_reg(input logic [CFG_W-1:0] top_val,
                                                input logic [CFG_W-1:0] rst_val,
                                                input int typical);
    case ($urandom_range(6))
      0:       return '0;
      1:       return top_val;
      2:       return rst_val;
      3:       return $urandom();
      default: return $urandom_range(typical, 0);
    endcase
  endfunction

  task automatic send_random_sample();
    int tgt, meas, dur, tgt_c, pick;
    pick = $urandom_range(99);
    if (pick < 5) tgt = 0;
    else if (pick < 20) tgt = int'($signed(16'($urandom())));
    else if (pick < 25) tgt = ($urandom_range(1) ? 1 : -1) * $urandom_range(15010, 14990);
    else tgt = $urandom_range(30000) - 15000;
    tgt_c = (tgt > 15000) ? 15000 : (tgt < -15000) ? -15000 : tgt;
    pick = $urandom_range(99);
    if (pick < 60) meas = tgt_c + $urandom_range(600) - 300;
    else if (pick < 80) meas = int'($signed(16'($urandom())));
    else meas = $urandom_range(30000) - 15000;
    pick = $urandom_range(99);
    if (pick < 5) dur = 0;
    else if (pick < 80) dur = $urandom_range(20, 1);
    else if (pick < 95) dur = $urandom_range(1000, 1);
    else dur = $urandom_range(65535);
    send_sample(tgt, meas, dur);
  endtask

  initial begin
    rst          = 1'b1;
    wr_en        = 1'b0;
    wr_index     = '0;
    wr_data      = '0;
    burst        = 1'b0;
    hold_requests = 0;
    in_ch.valid          = 1'b0;
    in_ch.target_speed   = '0;
    in_ch.measured_speed = '0;
    in_ch.elapsed_ms     = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Default gains: zero target, zero time, clamping, opposing sign, wind-up.
    send_sample(0, 0, 0);
    send_sample(0, 1234, 5);
    send_sample(1000, 0, 10);
    send_sample(1000, 900, 0);
    send_sample(32767, -32768, 65535);
    send_sample(-32768, 32767, 1);
    send_sample(-32767, 0, 100);
    send_sample(500, 5000, 10);
    send_sample(-500, -5000, 10);
    send_sample(15000, 0, 1000);
    send_sample(15001, 0, 1000);
    send_sample(-15001, 0, 1);
    send_sample(1, 0, 1);
    quiesce(SETTLE_CYCLES);

    // Every register at its top value, deadband above the power limit.
    write_reg(REG_PROP_GAIN, 32'h0000_FFFF);
    write_reg(REG_INTEG_GAIN, 32'h0000_FFFF);
    write_reg(REG_DERIV_GAIN, 32'h0000_FFFF);
    write_reg(REG_INTEGRAL_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_DEADBAND, 32'd1023);
    write_reg(REG_UNMAPPED, $urandom());
    send_sample(15000, -32768, 1);
    send_sample(-15000, 32767, 65535);
    send_sample(1, 1, 1);
    send_sample(0, -32768, 65535);
    send_sample(-1, 32767, 2);
    quiesce(SETTLE_CYCLES);

    // The accumulator now lies beyond the lowered limit and is clamped next time.
    write_reg(REG_INTEGRAL_LIMIT, 32'd1000);
    send_sample(-1, 0, 1);
    quiesce(SETTLE_CYCLES);

    // Proportional term alone, right at and just above the deadband threshold.
    write_reg(REG_PROP_GAIN, 32'd1);
    write_reg(REG_INTEG_GAIN, 32'd0);
    write_reg(REG_DERIV_GAIN, 32'd0);
    write_reg(REG_DEADBAND, 32'd1000);
    send_sample(2560, 0, 1);
    send_sample(2561, 0, 1);
    send_sample(-2561, 0, 1);
    quiesce(SETTLE_CYCLES);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(REG_PROP_GAIN, pick_reg(32'hFFFF, CFG_W'(PROP_GAIN_RST), 4095));
      write_reg(REG_INTEG_GAIN, pick_reg(32'hFFFF, CFG_W'(INTEG_GAIN_RST), 8191));
      write_reg(REG_DERIV_GAIN, pick_reg(32'hFFFF, CFG_W'(DERIV_GAIN_RST), 255));
      write_reg(REG_INTEGRAL_LIMIT, pick_reg(32'hFFFF_FFFF, INTEGRAL_LIMIT_RST, 2000000));
      write_reg(REG_DEADBAND, pick_reg(32'd1023, CFG_W'(DEADBAND_RST), 200));
      write_reg(REG_UNMAPPED + 3'($urandom_range(2)), $urandom());
      burst = (ph == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Hold the receiver off while samples keep coming, so the block backs up.
        if (ph == 5 && k == 40) hold_requests++;
        if (k % 97 == 96) quiesce(0);
        send_random_sample();
      end
      quiesce(SETTLE_CYCLES);
    end

    burst = 1'b0;
    quiesce(SETTLE_CYCLES);
    if (sb.expected_power.size() != 0) begin
      $display("%0t: drive_power beats missing: expected %0d more, actual none",
               $time, sb.expected_power.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> split_pid_speed_controller_unit.f
hw/rtl/spsc_pkg.sv
hw/rtl/spsc_if.sv
hw/rtl/split_pid_speed_controller_unit.sv
tb/tb_split_pid_speed_controller_unit.sv
